>>> rtl/m3inv_pkg.sv
// Shared types and constants for the 3x3 adjugate matrix inverter.
// Used by every module of the block but the checker; depends on nothing.
package m3inv_pkg;

    localparam int ORDER     = 3;
    localparam int CELLS     = ORDER * ORDER;
    localparam int IN_WIDTH  = 16;
    localparam int FRAC_BITS = IN_WIDTH / 2;
    localparam int OUT_FRAC  = 16;
    localparam int SHIFT     = FRAC_BITS + OUT_FRAC;
    localparam int PROD_W    = 2 * IN_WIDTH;
    localparam int ADJ_W     = PROD_W + 1;
    localparam int DET_W     = ADJ_W + IN_WIDTH + 1;
    localparam int NUM_W     = ADJ_W + SHIFT;
    localparam int OUT_W     = 32;
    localparam int CNT_W     = 4;
    localparam int BIT_CNT_W = $clog2(NUM_W);
    localparam int Q_DEPTH   = 2;

    typedef logic [CELLS-1:0][IN_WIDTH-1:0] t_mat;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUB,
        ST_DET,
        ST_CHK,
        ST_DINIT,
        ST_DIV,
        ST_EMIT
    } t_bstate;

endpackage

>>> rtl/m3inv_front.sv
// Input side: collects nine elements of one matrix and pushes the whole matrix.
// Depends on m3inv_pkg.
module m3inv_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [15:0]       i_data,
    input  m3inv_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output m3inv_pkg::t_mat   o_mat
);
    import m3inv_pkg::*;

    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic [IN_WIDTH-1:0] r_store [CELLS-1];
    logic                last_elem;
    logic                accept;

    assign last_elem = (r_cnt == CNT_W'(CELLS - 1));
    assign o_ready   = !last_elem || !i_q_stat.full;
    assign accept    = i_valid && o_ready;
    assign o_push    = accept && last_elem;

    always_comb begin
        for (int k = 0; k < CELLS - 1; k++) begin
            o_mat[k] = r_store[k];
        end
        o_mat[CELLS-1] = i_data;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            n_cnt = last_elem ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !last_elem) begin
            r_store[r_cnt[CNT_W-2:0]] <= i_data;
        end
    end

endmodule

>>> rtl/m3inv_queue.sv
// Short queue of complete matrices between the collector and the compute engine.
// Depends on m3inv_pkg.
module m3inv_queue #(
    parameter int DEPTH = m3inv_pkg::Q_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  m3inv_pkg::t_mat    i_mat,
    input  logic               i_pop,
    output m3inv_pkg::t_mat    o_mat,
    output m3inv_pkg::t_q_stat o_stat
);
    import m3inv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_mat             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_mat        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_mat;
        end
    end

endmodule

>>> rtl/m3inv_back.sv
// Compute engine: minors, determinant, then one bit-serial division per entry.
// Depends on m3inv_pkg; drives the output register of the block.
module m3inv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  m3inv_pkg::t_mat    i_mat,
    input  m3inv_pkg::t_q_stat i_q_stat,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_data,
    output logic               o_singular,
    output logic               o_last
);
    import m3inv_pkg::*;

    t_bstate r_state, n_state;

    t_mat                  r_mat;
    logic [1:0]            r_i, r_j, r_c;
    logic signed [PROD_W-1:0] r_p1, r_p2;
    logic signed [ADJ_W-1:0]  r_adj [CELLS];
    logic signed [DET_W-1:0]  r_det;
    logic [DET_W-2:0]      r_dmag;
    logic [NUM_W-1:0]      r_num;
    logic [DET_W-1:0]      r_rem;
    logic [ADJ_W-1:0]      r_q;
    logic                  r_ovf, r_neg, r_sing;
    logic [BIT_CNT_W-1:0]  r_bits;
    logic                  r_ovalid, r_osing, r_olast;
    logic [OUT_W-1:0]      r_odata;

    // control strobes
    logic do_pop, do_load, last_pos, out_free, div_done;

    logic [CNT_W-1:0] k_idx;
    logic [1:0]       row0, row1, col0, col1;
    logic signed [ADJ_W-1:0]  diff, adj_sel;
    logic signed [DET_W-1:0]  det_term;
    logic [ADJ_W-1:0]      adj_mag;
    logic [DET_W-1:0]      trial;
    logic                  take;
    logic [ADJ_W-1:0]      mag_out;
    logic [OUT_W-1:0]      res_val;

    function automatic logic signed [IN_WIDTH-1:0] elem(t_mat m, logic [1:0] r, logic [1:0] c);
        logic [CNT_W-1:0] idx;
        idx = CNT_W'(r) * CNT_W'(ORDER) + CNT_W'(c);
        return m[idx];
    endfunction

    assign k_idx    = CNT_W'(r_i) * CNT_W'(ORDER) + CNT_W'(r_j);
    assign last_pos = (r_i == 2'(ORDER - 1)) && (r_j == 2'(ORDER - 1));
    assign out_free = !r_ovalid || i_ready;
    assign div_done = (r_bits == BIT_CNT_W'(NUM_W - 1));

    // adjugate (i,j) is the minor without row j and column i
    assign row0 = (r_j == 2'd0) ? 2'd1 : 2'd0;
    assign row1 = (r_j == 2'd2) ? 2'd1 : 2'd2;
    assign col0 = (r_i == 2'd0) ? 2'd1 : 2'd0;
    assign col1 = (r_i == 2'd2) ? 2'd1 : 2'd2;

    assign diff     = ADJ_W'(r_p1) - ADJ_W'(r_p2);
    assign adj_sel  = r_adj[k_idx];
    assign adj_mag  = adj_sel[ADJ_W-1] ? ADJ_W'(-adj_sel) : ADJ_W'(adj_sel);
    assign det_term = DET_W'(elem(r_mat, 2'd0, r_c) * r_adj[CNT_W'(r_c) * CNT_W'(ORDER)]);
    assign trial    = {r_rem[DET_W-2:0], r_num[NUM_W-1]};
    assign take     = (trial >= DET_W'(r_dmag));

    always_comb begin
        mag_out = r_ovf ? '1 : r_q;
        if (r_neg) begin
            res_val = (mag_out > ADJ_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                          : OUT_W'(-mag_out);
        end else begin
            res_val = (mag_out > ADJ_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                          : OUT_W'(mag_out);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (!i_q_stat.empty) n_state = ST_MUL;
            ST_MUL:   n_state = ST_SUB;
            ST_SUB:   n_state = last_pos ? ST_DET : ST_MUL;
            ST_DET:   if (r_c == 2'(ORDER - 1)) n_state = ST_CHK;
            ST_CHK:   n_state = (r_det == '0) ? ST_EMIT : ST_DINIT;
            ST_DINIT: n_state = ST_DIV;
            ST_DIV:   if (div_done) n_state = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    n_state = (r_sing || last_pos) ? ST_IDLE : ST_DINIT;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        do_pop  = 1'b0;
        do_load = 1'b0;
        unique case (r_state)
            ST_IDLE: do_pop  = !i_q_stat.empty;
            ST_EMIT: do_load = out_free;
            default: ;
        endcase
    end

    assign o_pop      = do_pop;
    assign o_valid    = r_ovalid;
    assign o_data     = r_odata;
    assign o_singular = r_osing;
    assign o_last     = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_mat <= i_mat;
            r_i   <= '0;
            r_j   <= '0;
            r_c   <= '0;
            r_det <= '0;
            r_sing <= 1'b0;
        end
        if (r_state == ST_MUL) begin
            r_p1 <= elem(r_mat, row0, col0) * elem(r_mat, row1, col1);
            r_p2 <= elem(r_mat, row0, col1) * elem(r_mat, row1, col0);
        end
        if (r_state == ST_SUB) begin
            r_adj[k_idx] <= (r_i[0] ^ r_j[0]) ? -diff : diff;
            if (r_j == 2'(ORDER - 1)) begin
                r_j <= '0;
                r_i <= last_pos ? '0 : r_i + 1'b1;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
        if (r_state == ST_DET) begin
            r_det <= r_det + det_term;
            r_c   <= r_c + 1'b1;
        end
        if (r_state == ST_CHK) begin
            r_sing <= (r_det == '0);
            r_dmag <= r_det[DET_W-1] ? (DET_W-1)'(-r_det) : (DET_W-1)'(r_det);
        end
        if (r_state == ST_DINIT) begin
            r_neg  <= adj_sel[ADJ_W-1] ^ r_det[DET_W-1];
            r_num  <= {adj_mag, SHIFT'(0)};
            r_rem  <= '0;
            r_q    <= '0;
            r_ovf  <= 1'b0;
            r_bits <= '0;
        end
        if (r_state == ST_DIV) begin
            r_rem  <= take ? trial - DET_W'(r_dmag) : trial;
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_q    <= {r_q[ADJ_W-2:0], take};
            r_ovf  <= r_ovf | r_q[ADJ_W-1];
            r_bits <= r_bits + 1'b1;
        end
        if (do_load) begin
            r_odata <= r_sing ? '0 : res_val;
            r_osing <= r_sing;
            r_olast <= r_sing || last_pos;
            if (!r_sing) begin
                if (r_j == 2'(ORDER - 1)) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/matrix3_inverse_adjugate_top.sv
// Top level of the 3x3 matrix inverter by adjugate and fixed-point division.
// Depends on m3inv_pkg, m3inv_front, m3inv_queue and m3inv_back.
//
//   channel   | dir | tdata                       | tuser    | tlast
//   s_axis    | in  | [15:0] matrix_element Q8.8  | -        | -
//   m_axis    | out | [31:0] inverse_element Q16.16 | singular | last
//
// Input elements are taken one per cycle, the last of a matrix only while the queue
// is not full; a full matrix waits in a two-deep queue. Per matrix: a pop, minors,
// determinant, a check, then per entry a setup, one-bit-per-cycle division and an
// emit; the shared divider sets the rate. A singular matrix emits one result.
// Reset is synchronous and clears counters, queue pointers and output valid.
// Output stalls hold the engine; input stalls only while the queue is full.
module matrix3_inverse_adjugate_top #(
    parameter int QUEUE_DEPTH = m3inv_pkg::Q_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] matrix_element
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] inverse_element
    output logic        o_m_axis_tuser,   // [0] singular
    output logic        o_m_axis_tlast
);
    import m3inv_pkg::*;

    t_mat    w_push_mat, w_head_mat;
    t_q_stat w_q_stat;
    logic    w_push, w_pop;

    m3inv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_data   (i_s_axis_tdata),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_mat    (w_push_mat)
    );

    m3inv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_mat   (w_push_mat),
        .i_pop   (w_pop),
        .o_mat   (w_head_mat),
        .o_stat  (w_q_stat)
    );

    m3inv_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mat      (w_head_mat),
        .i_q_stat   (w_q_stat),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_data     (o_m_axis_tdata),
        .o_singular (o_m_axis_tuser),
        .o_last     (o_m_axis_tlast)
    );

endmodule

>>> rtl/m3inv_checker.sv
// Port-level checks for the matrix inverter, bound to the top level.
// Depends only on the top level's ports.
module m3inv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled transaction changed");

    a_sing_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("singular transaction without last");

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> (o_m_axis_tdata == 32'd0))
        else $error("singular transaction with nonzero data");

endmodule

bind matrix3_inverse_adjugate_top m3inv_checker u_m3inv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

>>> bench/matrix3_inverse_adjugate_top_tb.sv
// Testbench for the 3x3 adjugate matrix inverter: streams Q8.8 matrices in and
// checks every Q16.16 inverse entry against a behavioral predictor of the block.
// Depends on m3inv_pkg and matrix3_inverse_adjugate_top.
module matrix3_inverse_adjugate_top_tb;
    import m3inv_pkg::*;

    typedef struct {
        logic [31:0] inv_elem;
        logic        singular;
        logic        last;
    } t_inv_result;

    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 700;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;   // [31:0] inverse_element
    logic        o_m_axis_tuser;   // [0] singular
    logic        o_m_axis_tlast;

    t_inv_result pending_inv[$];
    int          errors = 0;
    int          idle_cycles = 0;
    bit          no_gaps = 1'b0;
    logic signed [15:0] mat_buf[CELLS];
    int          elem_idx = 0;

    matrix3_inverse_adjugate_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // 2x2 minor of the stored matrix with row r and column c removed
    function automatic longint minor2(int r, int c);
        int     ra, rb, ca, cb;
        longint a, b, x, y;
        ra = (r == 0) ? 1 : 0;
        rb = (r == 2) ? 1 : 2;
        ca = (c == 0) ? 1 : 0;
        cb = (c == 2) ? 1 : 2;
        a = mat_buf[ra*ORDER+ca];
        b = mat_buf[ra*ORDER+cb];
        x = mat_buf[rb*ORDER+ca];
        y = mat_buf[rb*ORDER+cb];
        return a * y - b * x;
    endfunction

    function automatic logic [31:0] div_saturate(longint adj, longint det);
        longint unsigned a, b, q;
        bit              neg;
        a   = (adj < 0) ? -adj : adj;
        b   = (det < 0) ? -det : det;
        neg = (adj < 0) != (det < 0);
        q   = (a << SHIFT) / b;
        if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    // predict the results of the matrix now held in mat_buf
    task automatic predict_inverse();
        longint      det, adj;
        t_inv_result r;
        det = 0;
        for (int c = 0; c < ORDER; c++) begin
            adj = longint'(mat_buf[c]) * minor2(0, c);
            det = (c & 1) ? det - adj : det + adj;
        end
        if (det == 0) begin
            r = '{32'd0, 1'b1, 1'b1};
            pending_inv.push_back(r);
            return;
        end
        for (int i = 0; i < ORDER; i++) begin
            for (int j = 0; j < ORDER; j++) begin
                adj = minor2(j, i);
                if ((i + j) & 1) adj = -adj;
                r.inv_elem = div_saturate(adj, det);
                r.singular = 1'b0;
                r.last     = (i == ORDER - 1 && j == ORDER - 1);
                pending_inv.push_back(r);
            end
        end
    endtask

    task automatic send_element(logic signed [15:0] elem);
        @(negedge i_clk);
        if (!no_gaps && $urandom_range(99) < 36) begin
            i_s_axis_tvalid = 1'b0;
            while ($urandom_range(99) < 36) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = elem;
        do @(posedge i_clk); while (!o_s_axis_tready);
        mat_buf[elem_idx] = elem;
        elem_idx++;
        if (elem_idx == CELLS) begin
            elem_idx = 0;
            predict_inverse();
        end
    endtask

    task automatic send_matrix(logic signed [15:0] m[CELLS]);
        foreach (m[k]) send_element(m[k]);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic test_directed();
        logic signed [15:0] m[CELLS];
        // det of one with large entries: saturates both ways
        m = '{16'sd1000, 16'sd999, 16'sd0, 16'sd1001, 16'sd1000, 16'sd0,
              16'sd0, 16'sd0, 16'sd1};
        send_matrix(m);
        // all most-negative: singular
        foreach (m[k]) m[k] = -16'sd32768;
        send_matrix(m);
        m = '{16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd32767, 16'sd0,
              16'sd0, 16'sd0, -16'sd32768};
        send_matrix(m);
    endtask

    task automatic random_matrix();
        logic signed [15:0] m[CELLS];
        int kind;
        kind = $urandom_range(9);
        foreach (m[k]) begin
            if (kind < 4) m[k] = 16'($urandom);
            else if (kind < 7) m[k] = 16'(int'($urandom_range(512)) - 256);
            else m[k] = 16'(int'($urandom_range(8)) - 4);
        end
        if (kind == 9) begin
            // repeated row forces a singular matrix
            for (int c = 0; c < ORDER; c++) m[2*ORDER+c] = m[c];
        end
        send_matrix(m);
    endtask

    task automatic wait_drain();
        drop_valid();
        while (pending_inv.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_random(int n);
        repeat (n) random_matrix();
    endtask

    task automatic test_no_idle_stretch(int n);
        no_gaps = 1'b1;
        repeat (n) random_matrix();
        no_gaps = 1'b0;
    endtask

    task automatic test_drain_pause();
        random_matrix();
        wait_drain();
        random_matrix();
    endtask

    always @(negedge i_clk)
        i_m_axis_tready <= no_gaps || ($urandom_range(99) >= 36);

    always @(posedge i_clk) begin
        t_inv_result e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_inv.size() == 0) begin
                $error("unexpected result transaction: tdata %h", o_m_axis_tdata);
                errors++;
            end else begin
                e = pending_inv.pop_front();
                if (o_m_axis_tdata !== e.inv_elem) begin
                    $error("inverse_element: expected %h actual %h", e.inv_elem,
                           o_m_axis_tdata);
                    errors++;
                end
                if (o_m_axis_tuser !== e.singular) begin
                    $error("singular: expected %b actual %b", e.singular, o_m_axis_tuser);
                    errors++;
                end
                if (o_m_axis_tlast !== e.last) begin
                    $error("last: expected %b actual %b", e.last, o_m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("matrix3_inverse_adjugate_top test failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(20);
        test_no_idle_stretch(8);
        test_drain_pause();
        test_random(16);
        wait_drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending_inv.size() == 0)
            $display("matrix3_inverse_adjugate_top test passed");
        else
            $display("matrix3_inverse_adjugate_top test failed");
        $finish;
    end
endmodule
